[design/bpa_pkg.sv]
// -----------------------------------------------------------------------------
// bpa_pkg - shared types and constants for the bitmap port allocator
// Request and result beat layouts, request codes, sequencer states and the
// bitmap word geometry.
// -----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

   // Port number width and default port space limits
   localparam int PORT_W          = 16;
   localparam int PORT_SPACE_DEF  = 65536;
   localparam int LAST_ALLOC_DEF  = 49151;

   // Reset value of the start port register
   localparam logic [PORT_W-1:0] START_RESET = 16'd1024;

   // Bitmap word geometry: one bit per port, searched by byte group and then by bit
   localparam int WORD_BITS  = 64;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int BYTE_COUNT = WORD_BITS / 8;
   localparam int BSEL_W     = $clog2(BYTE_COUNT);

   // Request codes
   localparam logic [1:0] REQ_MARK  = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_ALLOC = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXAM,
      ST_PICK,
      ST_DONE
   } state_type;

   // Request beat
   typedef struct packed {
      logic [1:0]        req_type;
      logic [PORT_W-1:0] port;
      logic              mark_used;
   } bpa_req_type;

   // Result beat
   typedef struct packed {
      logic [PORT_W-1:0] result_port;
      logic              found;
      logic              port_used;
   } bpa_rsp_type;

endpackage

`default_nettype wire

[design/bpa_bitmap_ram.sv]
// -----------------------------------------------------------------------------
// bpa_bitmap_ram - in-use bitmap storage
// One write port and one read port, read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module bpa_bitmap_ram #(
   parameter int DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [bpa_pkg::WORD_BITS-1:0]    wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [bpa_pkg::WORD_BITS-1:0]    rd_data
);
   import bpa_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Write one word, read one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/bitmap_port_allocator_top.sv]
// -----------------------------------------------------------------------------
// bitmap_port_allocator_top - first-fit port allocator over an in-use bitmap
// Marks, queries and allocates port numbers; one result beat per request.
// -----------------------------------------------------------------------------
// Usage: after reset the block sweeps the bitmap to zero, one word a cycle,
// and holds req_stall high until the sweep is done. Requests are taken one
// at a time and req_stall is high while one is in flight. A mark or query
// reads its bitmap word, examines it and then presents its result. An
// allocate fetches and examines each 64-port bitmap word it scans from
// start_port upward, since every word passes through the single read port of
// the bitmap RAM and then the one find-first-free search; a grant adds a pick
// state before the result, and a scan that finds no free port is answered
// once the last word in range is examined. A request with a port beyond the
// map, an allocate with start_port past the limit, or an unused code is
// answered without a bitmap read. The next request can be taken in the cycle
// each result turns valid, and may be accepted while that result still waits
// on rsp_stall. Write start_port through csr_wr_en/csr_wr_data only while the
// block is idle; the block itself does not enforce this.
// -----------------------------------------------------------------------------
`default_nettype none

module bitmap_port_allocator_top #(
   parameter int PORT_SPACE      = bpa_pkg::PORT_SPACE_DEF,
   parameter int LAST_ALLOC_PORT = bpa_pkg::LAST_ALLOC_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [bpa_pkg::PORT_W-1:0]    csr_wr_data,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire bpa_pkg::bpa_req_type          req_data,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      bpa_pkg::bpa_rsp_type          rsp_data
);
   import bpa_pkg::*;

   localparam int MAP_WORDS = (PORT_SPACE + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = $clog2(MAP_WORDS);
   localparam int SCAN_LAST = (LAST_ALLOC_PORT < PORT_SPACE - 1) ?
                              LAST_ALLOC_PORT : PORT_SPACE - 1;
   localparam int LAST_WORD = SCAN_LAST / WORD_BITS;
   localparam int LAST_BIT  = SCAN_LAST % WORD_BITS;
   localparam logic [WORD_BITS-1:0] HI_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - LAST_BIT);

   // Registers
   state_type              state_ff,    state_in;
   bpa_req_type            req_ff,      req_in;
   logic [ADDR_W-1:0]      word_ff,     word_in;
   logic                   first_ff,    first_in;
   logic [BSEL_W-1:0]      bsel_ff,     bsel_in;
   logic [7:0]             byte_ff,     byte_in;
   bpa_rsp_type            res_ff,      res_in;
   logic [ADDR_W-1:0]      clr_ff,      clr_in;
   logic [PORT_W-1:0]      start_ff,    start_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bpa_rsp_type            rsp_ff,      rsp_in;

   // Bitmap RAM signals
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic [WORD_BITS-1:0]   rd_data;

   // Decode and search signals
   logic                   req_acc;
   logic                   clr_last;
   logic                   port_in_map;
   logic                   start_ok;
   logic                   at_last;
   logic                   out_free;
   logic [PORT_W-1:0]      req_word_full;
   logic [PORT_W-1:0]      start_word_full;
   logic [BIT_W-1:0]       req_bit;
   logic [WORD_BITS-1:0]   lo_mask;
   logic [WORD_BITS-1:0]   cand;
   logic [BYTE_COUNT-1:0]  byte_any;
   logic                   cand_any;
   logic [BSEL_W-1:0]      cand_bsel;
   logic [7:0]             cand_byte;
   logic [2:0]             pick_bit;
   logic [BIT_W-1:0]       pick_pos;

   bpa_bitmap_ram #(
      .DEPTH (MAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (word_ff),
      .rd_data (rd_data)
   );

   // Handshake and request decode
   assign req_stall       = (state_ff != ST_IDLE);
   assign req_acc         = req_valid && !req_stall;
   assign clr_last        = (clr_ff == ADDR_W'(MAP_WORDS - 1));
   assign port_in_map     = ({1'b0, req_data.port} < 17'(PORT_SPACE));
   assign start_ok        = (start_ff <= PORT_W'(SCAN_LAST));
   assign req_word_full   = req_data.port >> BIT_W;
   assign start_word_full = start_ff >> BIT_W;
   assign req_bit         = req_ff.port[BIT_W-1:0];
   assign at_last         = (word_ff == ADDR_W'(LAST_WORD));
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   // Free-port candidates in the current word, inside the scan window
   assign lo_mask = first_ff ? ({WORD_BITS{1'b1}} << start_ff[BIT_W-1:0])
                             : {WORD_BITS{1'b1}};
   assign cand    = ~rd_data & lo_mask & (at_last ? HI_MASK : {WORD_BITS{1'b1}});
   assign cand_any = |cand;

   // Find the lowest byte group holding a free port
   always_comb begin
      cand_bsel = '0;
      cand_byte = '0;
      for (int b = 0; b < BYTE_COUNT; b++) begin
         byte_any[b] = |cand[b*8 +: 8];
      end
      for (int b = BYTE_COUNT - 1; b >= 0; b--) begin
         if (byte_any[b]) begin
            cand_bsel = BSEL_W'(b);
            cand_byte = cand[b*8 +: 8];
         end
      end
   end

   // Find the lowest free bit inside the chosen byte
   always_comb begin
      pick_bit = '0;
      for (int i = 7; i >= 0; i--) begin
         if (byte_ff[i]) begin
            pick_bit = 3'(i);
         end
      end
   end
   assign pick_pos = {bsel_ff, pick_bit};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               case (req_data.req_type)
                  REQ_MARK, REQ_QUERY:
                     state_in = port_in_map ? ST_FETCH : ST_DONE;
                  REQ_ALLOC:
                     state_in = start_ok ? ST_FETCH : ST_DONE;
                  default:
                     state_in = ST_DONE;
               endcase
            end
         end
         ST_FETCH: state_in = ST_EXAM;
         ST_EXAM: begin
            if (req_ff.req_type == REQ_ALLOC) begin
               if (cand_any) begin
                  state_in = ST_PICK;
               end else if (at_last) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FETCH;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PICK: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      req_in       = req_ff;
      word_in      = word_ff;
      first_in     = first_ff;
      bsel_in      = bsel_ff;
      byte_in      = byte_ff;
      res_in       = res_ff;
      clr_in       = clr_ff;
      start_in     = csr_wr_en ? csr_wr_data : start_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = word_ff;
      wr_data      = rd_data;
      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep zeros through the bitmap
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_acc) begin
               req_in   = req_data;
               first_in = 1'b1;
               res_in   = '0;
               case (req_data.req_type)
                  REQ_MARK, REQ_QUERY: begin
                     word_in            = req_word_full[ADDR_W-1:0];
                     res_in.result_port = req_data.port;
                  end
                  REQ_ALLOC: begin
                     word_in = start_word_full[ADDR_W-1:0];
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         ST_FETCH: begin
         end
         ST_EXAM: begin
            case (req_ff.req_type)
               REQ_MARK: begin
                  // Set or clear the addressed bit
                  wr_en = 1'b1;
                  if (req_ff.mark_used) begin
                     wr_data = rd_data | (WORD_BITS'(1) << req_bit);
                  end else begin
                     wr_data = rd_data & ~(WORD_BITS'(1) << req_bit);
                  end
                  res_in.port_used = req_ff.mark_used;
               end
               REQ_QUERY: begin
                  res_in.port_used = rd_data[req_bit];
               end
               default: begin
                  // Allocate: hold the winning byte or advance to next word
                  if (cand_any) begin
                     bsel_in = cand_bsel;
                     byte_in = cand_byte;
                  end else if (!at_last) begin
                     word_in  = word_ff + ADDR_W'(1);
                     first_in = 1'b0;
                  end
               end
            endcase
         end
         ST_PICK: begin
            // Claim the free port
            wr_en              = 1'b1;
            wr_data            = rd_data | (WORD_BITS'(1) << pick_pos);
            res_in.result_port = PORT_W'({word_ff, pick_pos});
            res_in.found       = 1'b1;
            res_in.port_used   = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         start_ff     <= START_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      word_ff  <= word_in;
      first_ff <= first_in;
      bsel_ff  <= bsel_in;
      byte_ff  <= byte_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
